// ----- rtl/bitmap_allocator_find_first_clear_macros.svh -----
// Assertion macros for the bitmap allocator checker.
`ifndef BITMAP_ALLOCATOR_FIND_FIRST_CLEAR_MACROS_SVH
`define BITMAP_ALLOCATOR_FIND_FIRST_CLEAR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BAFC_AST_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bafc: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BAFC_AST_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bafc: next-cycle check failed");

// Consequent must hold in the cycle after reset.
`define BAFC_AST_RESET(label, cons) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("bafc: post-reset check failed");

`endif

// ----- rtl/bafc_pkg.sv -----
package bafc_pkg;

   localparam int NUM_BITS  = 4096;
   localparam int WORD_BITS = 32;
   localparam int NUM_WORDS = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int IDX_W     = $clog2(NUM_BITS);
   localparam int CNT_W     = IDX_W + 1;
   localparam int BIT_AW    = $clog2(WORD_BITS);
   localparam int WORD_AW   = $clog2(NUM_WORDS);

   localparam logic [CNT_W-1:0] COUNT_MAX   = CNT_W'(NUM_BITS);
   localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(4096);

   typedef enum logic [1:0] {
      OP_SET   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_TEST  = 2'd2,
      OP_FIND  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_NONE  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_FIND_CHECK,
      S_RESPOND
   } state_type;

   typedef struct packed {
      logic               rd_en;
      logic [WORD_AW-1:0] rd_addr;
      logic               wr_en;
      logic [WORD_AW-1:0] wr_addr;
      logic [WORD_BITS-1:0] wr_data;
   } mem_req_type;

   typedef struct packed {
      opcode_type        op;
      logic [BIT_AW-1:0] bit_sel;
      logic [CNT_W-1:0]  remaining;
   } word_ctl_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] new_word;
      logic                 bit_value;
      logic                 found;
      logic [BIT_AW-1:0]    found_pos;
   } word_res_type;

endpackage

// ----- rtl/bafc_channels.sv -----
interface bafc_req_if;
   import bafc_pkg::*;
   logic             valid;
   logic             ready;
   logic [1:0]       opcode;
   logic [IDX_W-1:0] bit_index;

   modport source (output valid, output opcode, output bit_index, input ready);
   modport sink   (input valid, input opcode, input bit_index, output ready);
   modport mon    (input valid, input opcode, input bit_index, input ready);
endinterface

interface bafc_rsp_if;
   import bafc_pkg::*;
   logic             valid;
   logic             ready;
   logic             bit_value;
   logic [IDX_W-1:0] found_index;
   logic [1:0]       status;

   modport source (output valid, output bit_value, output found_index, output status,
                   input ready);
   modport sink   (input valid, input bit_value, input found_index, input status,
                   output ready);
   modport mon    (input valid, input bit_value, input found_index, input status,
                   input ready);
endinterface

// ----- rtl/bafc_map_store.sv -----
module bafc_map_store
   import bafc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  mem_req_type          mem_req,
   output logic [WORD_BITS-1:0] rd_word
);

   logic [WORD_BITS-1:0] mem_ff [NUM_WORDS];
   logic [NUM_WORDS-1:0] valid_ff;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_valid_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_req.wr_en) begin
            valid_ff[mem_req.wr_addr] <= 1'b1;
         end
         if (mem_req.rd_en) begin
            rd_valid_ff <= valid_ff[mem_req.rd_addr];
         end
      end
   end

   assign rd_word = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ----- rtl/bafc_word_unit.sv -----
module bafc_word_unit
   import bafc_pkg::*;
(
   input  logic [WORD_BITS-1:0] word,
   input  word_ctl_type         ctl,
   output word_res_type         res
);

   logic [WORD_BITS-1:0] onehot;
   logic [WORD_BITS-1:0] limit;
   logic [WORD_BITS-1:0] free_bits;

   always_comb begin
      onehot = WORD_BITS'(1) << ctl.bit_sel;
      if (ctl.remaining >= CNT_W'(WORD_BITS)) begin
         limit = '1;
      end else begin
         limit = ~({WORD_BITS{1'b1}} << ctl.remaining[BIT_AW-1:0]);
      end
      free_bits = ~word & limit;

      res.new_word  = (ctl.op == OP_SET) ? (word | onehot) : (word & ~onehot);
      res.bit_value = word[ctl.bit_sel];
      res.found     = |free_bits;
      res.found_pos = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            res.found_pos = BIT_AW'(b);
         end
      end
   end

endmodule

// ----- rtl/bitmap_allocator_find_first_clear.sv -----
// Set, clear and test go through read, modify/write and respond; an out-of-range
// request goes straight to respond; find reads and checks words from word 0 on.
// The input reopens as the result register loads, so only one request is in
// flight at a time; a result that waits in the register stalls the next one.
// Synchronous active-high reset clears the map through per-word valid bits at once,
// sets the element count (count_ff) to 4096 and empties the result register.
module bitmap_allocator_find_first_clear
   import bafc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   bafc_req_if.sink         req_chan,
   bafc_rsp_if.source       rsp_chan,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data
);

   state_type            state_ff, state_in;
   opcode_type           op_ff, op_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [WORD_AW-1:0]   ptr_ff, ptr_in;
   logic [CNT_W-1:0]     count_ff;
   logic                 res_bit_ff, res_bit_in;
   logic [IDX_W-1:0]     res_found_ff, res_found_in;
   status_type           res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_bit_ff, rsp_bit_in;
   logic [IDX_W-1:0]     rsp_found_ff, rsp_found_in;
   status_type           rsp_status_ff, rsp_status_in;

   logic [CNT_W-1:0]     count_eff;
   logic [CNT_W-1:0]     remaining;
   logic                 last_word;
   mem_req_type          mem_req;
   logic [WORD_BITS-1:0] rd_word;
   word_ctl_type         word_ctl;
   word_res_type         word_res;

   bafc_map_store u_store (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_word (rd_word)
   );

   bafc_word_unit u_word (
      .word (rd_word),
      .ctl  (word_ctl),
      .res  (word_res)
   );

   assign count_eff = (count_ff > COUNT_MAX) ? COUNT_MAX : count_ff;
   assign remaining = count_eff - CNT_W'({ptr_ff, {BIT_AW{1'b0}}});
   assign last_word = (remaining <= CNT_W'(WORD_BITS)) ||
                      (ptr_ff == WORD_AW'(NUM_WORDS - 1));

   assign word_ctl.op        = op_ff;
   assign word_ctl.bit_sel   = idx_ff[BIT_AW-1:0];
   assign word_ctl.remaining = remaining;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      ptr_in        = ptr_ff;
      res_bit_in    = res_bit_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_chan.ready;
      rsp_bit_in    = rsp_bit_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      mem_req       = '0;
      req_chan.ready = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in        = opcode_type'(req_chan.opcode);
               idx_in       = req_chan.bit_index;
               res_bit_in   = 1'b0;
               res_found_in = '0;
               if (opcode_type'(req_chan.opcode) == OP_FIND) begin
                  if (count_eff == '0) begin
                     res_status_in = ST_NONE;
                     state_in      = S_RESPOND;
                  end else begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = '0;
                     ptr_in          = '0;
                     state_in        = S_FIND_CHECK;
                  end
               end else if ({1'b0, req_chan.bit_index} >= count_eff) begin
                  res_status_in = ST_RANGE;
                  state_in      = S_RESPOND;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = req_chan.bit_index[IDX_W-1:BIT_AW];
                  state_in        = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            if (op_ff != OP_TEST) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = idx_ff[IDX_W-1:BIT_AW];
               mem_req.wr_data = word_res.new_word;
            end
            res_bit_in    = (op_ff == OP_TEST) ? word_res.bit_value : 1'b0;
            res_status_in = ST_OK;
            state_in      = S_RESPOND;
         end
         S_FIND_CHECK: begin
            if (word_res.found) begin
               res_found_in  = {ptr_ff, word_res.found_pos};
               res_status_in = ST_OK;
               state_in      = S_RESPOND;
            end else if (last_word) begin
               res_status_in = ST_NONE;
               state_in      = S_RESPOND;
            end else begin
               ptr_in          = ptr_ff + 1'b1;
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = ptr_ff + 1'b1;
            end
         end
         S_RESPOND: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_bit_in    = res_bit_ff;
               rsp_found_in  = res_found_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      ptr_ff        <= ptr_in;
      res_bit_ff    <= res_bit_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      rsp_bit_ff    <= rsp_bit_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.bit_value   = rsp_bit_ff;
   assign rsp_chan.found_index = rsp_found_ff;
   assign rsp_chan.status      = rsp_status_ff;

endmodule

// ----- rtl/bafc_checker.sv -----
`include "bitmap_allocator_find_first_clear_macros.svh"

module bafc_checker
   import bafc_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_bit_value,
   input logic [IDX_W-1:0] rsp_found_index,
   input logic [1:0]       rsp_status
);

   logic             req_fire;
   logic             rsp_stall;
   logic             rsp_fail;
   logic [IDX_W+2:0] rsp_payload;

   assign req_fire    = req_valid && req_ready;
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_fail    = rsp_valid && (rsp_status != ST_OK);
   assign rsp_payload = {rsp_bit_value, rsp_found_index, rsp_status};

   `BAFC_AST_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_payload))
   `BAFC_AST_SAME(a_err_clean, rsp_fail, !rsp_bit_value && (rsp_found_index == '0))
   `BAFC_AST_NEXT(a_one_in_flight, req_fire, !req_ready)
   `BAFC_AST_RESET(a_reset_empty, !rsp_valid && req_ready)

endmodule

bind bitmap_allocator_find_first_clear bafc_checker u_bafc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_bit_value   (rsp_chan.bit_value),
   .rsp_found_index (rsp_chan.found_index),
   .rsp_status      (rsp_chan.status)
);
